[src/afsk_pkg.sv]
// Shared types, constants and the phase helper function of the AFSK NRZI modulator.
`default_nettype none

package afsk_pkg;

  localparam int PORTS           = 8;
  localparam int SAMPLES_PER_BIT = 11;
  localparam int TABLE_LEN       = 66;

  localparam int PORT_W = 3;
  localparam int PH_W   = $clog2(TABLE_LEN);
  localparam int CNT_W  = $clog2(SAMPLES_PER_BIT);

  localparam int MARK_STEP_I  = 6;
  localparam int SPACE_STEP_I = 11;

  localparam logic [PH_W-1:0] MARK_STEP  = PH_W'(MARK_STEP_I);
  localparam logic [PH_W-1:0] SPACE_STEP = PH_W'(SPACE_STEP_I);
  // Phase advance over one whole bit period, folded into the table.
  localparam logic [PH_W-1:0] MARK_OFS  = PH_W'((SAMPLES_PER_BIT * MARK_STEP_I) % TABLE_LEN);
  localparam logic [PH_W-1:0] SPACE_OFS = PH_W'((SAMPLES_PER_BIT * SPACE_STEP_I) % TABLE_LEN);

  localparam logic signed [7:0] LEVEL_MARK  = -8'sd128;
  localparam logic signed [7:0] LEVEL_SPACE = 8'sd127;

  localparam logic [5:0] FULL_LIMIT = 6'd24;
  localparam logic [5:0] BYTE_BITS  = 6'd8;
  localparam logic [5:0] HOLD_EXTRA = 6'd8;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic REG_ACTIVE_PORTS = 1'b0;
  localparam logic REG_LEVEL_MASK   = 1'b1;

  localparam logic signed [7:0] COS_WAVE [TABLE_LEN] = '{
    8'sd90, 8'sd90, 8'sd88, 8'sd86, 8'sd84, 8'sd80, 8'sd76, 8'sd71, 8'sd65, 8'sd59, 8'sd52,
    8'sd45, 8'sd37, 8'sd29, 8'sd21, 8'sd13, 8'sd4, -8'sd4, -8'sd13, -8'sd21, -8'sd29, -8'sd37,
    -8'sd45, -8'sd52, -8'sd59, -8'sd65, -8'sd71, -8'sd76, -8'sd80, -8'sd84, -8'sd86, -8'sd88,
    -8'sd90, -8'sd90, -8'sd90, -8'sd88, -8'sd86, -8'sd84, -8'sd80, -8'sd76, -8'sd71, -8'sd65,
    -8'sd59, -8'sd52, -8'sd45, -8'sd37, -8'sd29, -8'sd21, -8'sd13, -8'sd4, 8'sd4, 8'sd13,
    8'sd21, 8'sd29, 8'sd37, 8'sd45, 8'sd52, 8'sd59, 8'sd65, 8'sd71, 8'sd76, 8'sd80, 8'sd84,
    8'sd86, 8'sd88, 8'sd90
  };

  typedef enum logic [2:0] {
    KIND_SAMPLE   = 3'd0,
    KIND_ACCEPTED = 3'd1,
    KIND_REJECTED = 3'd2,
    KIND_IDLE     = 3'd3,
    KIND_PTT_OFF  = 3'd4,
    KIND_BAD_PORT = 3'd5
  } kind_t;

  typedef struct packed {
    logic              mode;
    logic [PORT_W-1:0] port;
    logic [7:0]        data_byte;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic signed [7:0] sample;
    logic              dac_enable;
    logic [PORT_W-1:0] out_port;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [31:0]     queue;
    logic [5:0]      count;
    logic [PH_W-1:0] phase;
    logic            level;
    logic [5:0]      hold;
  } port_state_t;

  // Work handed from the read-modify-write stage to the sample generator.
  typedef struct packed {
    logic              is_tick;
    logic              flat;
    logic              level;
    logic [PH_W-1:0]   phase;
    kind_t             kind;
    logic              dac;
    logic [PORT_W-1:0] port;
  } job_t;

  // Adds two phases that are both below the table length and wraps once.
  function automatic logic [PH_W-1:0] phase_add(logic [PH_W-1:0] ph, logic [PH_W-1:0] inc);
    logic [PH_W:0] sum;
    sum = {1'b0, ph} + {1'b0, inc};
    if (sum >= (PH_W+1)'(TABLE_LEN)) begin
      sum = sum - (PH_W+1)'(TABLE_LEN);
    end
    return sum[PH_W-1:0];
  endfunction

endpackage

`default_nettype wire

[src/afsk_state_ram.sv]
// Per-port state memory with registered read and reset-cleared valid bits.
`default_nettype none

module afsk_state_ram (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        re,
  input  logic [afsk_pkg::PORT_W-1:0] raddr,
  output afsk_pkg::port_state_t       rdata,
  input  logic                        we,
  input  logic [afsk_pkg::PORT_W-1:0] waddr,
  input  afsk_pkg::port_state_t       wdata
);
  import afsk_pkg::*;

  port_state_t      mem [PORTS];
  port_state_t      rdata_r;
  logic             rvld_r;
  logic [PORTS-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        rvld_r <= vld_r[raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // An entry never written since reset reads as all zero.
  assign rdata = rvld_r ? rdata_r : '0;

endmodule

`default_nettype wire

[src/afsk_sample_gen.sv]
// Result sequencer: emits single status results and the sample burst of a bit tick.
`default_nettype none

module afsk_sample_gen (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  input  afsk_pkg::job_t       job,
  output logic                 job_ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output afsk_pkg::out_item_t  out_data
);
  import afsk_pkg::*;

  logic              out_valid_r;
  out_item_t         out_r;
  logic [CNT_W-1:0]  rem_r;
  logic [PH_W-1:0]   ph_r;
  logic              lvl_r;
  logic              flat_r;
  logic [PORT_W-1:0] port_r;

  logic              adv;
  logic              busy;
  logic [PH_W-1:0]   ph_base;
  logic [PH_W-1:0]   ph_nxt;
  logic              lvl;
  logic              flat;
  logic signed [7:0] smp;

  assign adv       = !out_valid_r || !out_stall;
  assign busy      = (rem_r != '0);
  assign job_ready = adv && !busy;

  always_comb begin
    ph_base = busy ? ph_r : job.phase;
    lvl     = busy ? lvl_r : job.level;
    flat    = busy ? flat_r : job.flat;
    if (flat) begin
      ph_nxt = ph_base;
      smp    = lvl ? LEVEL_MARK : LEVEL_SPACE;
    end else begin
      ph_nxt = phase_add(ph_base, lvl ? MARK_STEP : SPACE_STEP);
      smp    = COS_WAVE[ph_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rem_r       <= '0;
    end else if (adv) begin
      if (busy) begin
        out_valid_r <= 1'b1;
        rem_r       <= rem_r - CNT_W'(1);
      end else if (job_valid) begin
        out_valid_r <= 1'b1;
        rem_r       <= job.is_tick ? CNT_W'(SAMPLES_PER_BIT - 1) : '0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (busy) begin
        out_r.kind       <= KIND_SAMPLE;
        out_r.sample     <= smp;
        out_r.dac_enable <= 1'b0;
        out_r.out_port   <= port_r;
        out_r.last       <= (rem_r == CNT_W'(1));
        ph_r             <= ph_nxt;
      end else if (job_valid) begin
        ph_r   <= ph_nxt;
        lvl_r  <= job.level;
        flat_r <= job.flat;
        port_r <= job.port;
        out_r.out_port <= job.port;
        if (job.is_tick) begin
          out_r.kind       <= KIND_SAMPLE;
          out_r.sample     <= smp;
          out_r.dac_enable <= 1'b0;
          out_r.last       <= (SAMPLES_PER_BIT == 1);
        end else begin
          out_r.kind       <= job.kind;
          out_r.sample     <= '0;
          out_r.dac_enable <= job.dac;
          out_r.last       <= 1'b1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

[src/afsk_nrzi_modulator.sv]
// Top level of the multi-port AFSK modulator with NRZI coding and keying hold.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    in_item_t: mode, port, data_byte
//   out      output     out_valid / out_stall  out_item_t: kind, sample, dac_enable,
//                                                          out_port, last
//   cfg      input      psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// Push, idle tick and bad port give one result each and can follow every cycle unless stalled;
// a bit tick gives eleven samples, one per cycle unless stalled, holding the result sequencer.
// Port state is read at the edge that takes a request and written back when its job is taken,
// as the first result is registered; a request to the port being written takes forwarded state.
// Reset is synchronous; valid bits cleared at reset make unwritten ports read as zero.
// An output stall freezes the result register and, with a request waiting, the input too.
`default_nettype none

module afsk_nrzi_modulator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  afsk_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output afsk_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import afsk_pkg::*;

  logic [3:0]  active_ports_r;
  logic [7:0]  level_mask_r;

  logic        s1_valid_r;
  in_item_t    s1_item_r;
  logic        fwd_r;
  port_state_t fwd_st_r;

  port_state_t ram_rdata;
  port_state_t cur_st;
  port_state_t st_nxt;
  job_t        job;
  logic        job_ready;
  logic        fire;
  logic        we;
  logic        in_accept;
  logic        bad;
  logic        new_level;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_ports_r <= 4'd1;
      level_mask_r   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ACTIVE_PORTS: active_ports_r <= pwdata[3:0];
        REG_LEVEL_MASK:   level_mask_r   <= pwdata[7:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ACTIVE_PORTS: prdata = {28'd0, active_ports_r};
      REG_LEVEL_MASK:   prdata = {24'd0, level_mask_r};
      default:          prdata = '0;
    endcase
  end

  assign fire      = s1_valid_r && job_ready;
  assign in_stall  = s1_valid_r && !fire;
  assign in_accept = in_valid && !in_stall;
  assign we        = fire && !bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
        // The memory returns the old entry when it is read while being written.
        fwd_r      <= we && (s1_item_r.port == in_data.port);
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
      fwd_st_r  <= st_nxt;
    end
  end

  afsk_state_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (in_accept),
    .raddr (in_data.port),
    .rdata (ram_rdata),
    .we    (we),
    .waddr (s1_item_r.port),
    .wdata (st_nxt)
  );

  assign cur_st = fwd_r ? fwd_st_r : ram_rdata;

  always_comb begin
    bad = ({1'b0, s1_item_r.port} >= active_ports_r) || (32'(s1_item_r.port) >= PORTS);
    new_level   = cur_st.level ^ !cur_st.queue[0];
    st_nxt      = cur_st;
    job.is_tick = 1'b0;
    job.flat    = level_mask_r[s1_item_r.port];
    job.level   = new_level;
    job.phase   = cur_st.phase;
    job.kind    = KIND_BAD_PORT;
    job.dac     = 1'b0;
    job.port    = s1_item_r.port;
    if (!bad) begin
      if (s1_item_r.mode == MODE_PUSH) begin
        if (cur_st.count > FULL_LIMIT) begin
          job.kind = KIND_REJECTED;
        end else begin
          job.kind     = KIND_ACCEPTED;
          job.dac      = (cur_st.hold == '0);
          st_nxt.queue = cur_st.queue | (32'(s1_item_r.data_byte) << cur_st.count[4:0]);
          st_nxt.count = cur_st.count + BYTE_BITS;
          st_nxt.hold  = cur_st.count + BYTE_BITS + HOLD_EXTRA;
        end
      end else if (cur_st.count != '0) begin
        job.is_tick  = 1'b1;
        job.kind     = KIND_SAMPLE;
        st_nxt.level = new_level;
        st_nxt.queue = cur_st.queue >> 1;
        st_nxt.count = cur_st.count - 6'd1;
        // The stored phase moves straight to where the burst will leave it.
        if (!job.flat) begin
          st_nxt.phase = phase_add(cur_st.phase, new_level ? MARK_OFS : SPACE_OFS);
        end
      end else if (cur_st.hold != '0) begin
        st_nxt.hold = cur_st.hold - 6'd1;
        job.kind    = (cur_st.hold == 6'd1) ? KIND_PTT_OFF : KIND_IDLE;
      end else begin
        job.kind = KIND_IDLE;
      end
    end
  end

  afsk_sample_gen u_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (s1_valid_r),
    .job       (job),
    .job_ready (job_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[src/afsk_checker.sv]
// Port-level checks of the AFSK modulator and the bind that attaches them.
`default_nettype none

module afsk_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input afsk_pkg::out_item_t out_data
);
  import afsk_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  a_status_zero_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind != KIND_SAMPLE) |-> (out_data.sample == 8'sd0) && out_data.last)
    else $error("status result carries a sample or is not final");

  a_dac_only_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.dac_enable |-> (out_data.kind == KIND_ACCEPTED))
    else $error("dac enable on a result other than an accepted push");

  a_burst_port: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_data.kind == KIND_SAMPLE) && !out_data.last
      |=> out_valid && (out_data.kind == KIND_SAMPLE) && (out_data.out_port == $past(out_data.out_port)))
    else $error("sample burst broken or switched port");

endmodule

bind afsk_nrzi_modulator afsk_checker u_afsk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
